[rtl/cse_pkg.sv]
// Shared types, character codes and decode helpers for the C string unescaper.
// No dependencies; used by every module under rtl.
`default_nettype none

package cse_pkg;

   localparam int HEX_DIGITS_MAX = 4;
   localparam int OCT_DIGITS_MAX = 3;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CH_BSL = 8'h5C;
   localparam logic [7:0] CH_X   = 8'h78;
   localparam logic [7:0] CH_0   = 8'h30;
   localparam logic [7:0] CH_7   = 8'h37;
   localparam logic [7:0] CH_9   = 8'h39;
   localparam logic [7:0] CH_LA  = 8'h61;
   localparam logic [7:0] CH_LF  = 8'h66;
   localparam logic [7:0] CH_UA  = 8'h41;
   localparam logic [7:0] CH_UF  = 8'h46;
   localparam logic [7:0] CH_N   = 8'h6E;
   localparam logic [7:0] CH_T   = 8'h74;
   localparam logic [7:0] CH_V   = 8'h76;
   localparam logic [7:0] CH_B   = 8'h62;
   localparam logic [7:0] CH_R   = 8'h72;

   typedef enum logic [3:0] {
      MODE_TEXT = 4'b0001,
      MODE_ESC  = 4'b0010,
      MODE_HEX  = 4'b0100,
      MODE_OCT  = 4'b1000
   } mode_type;

   typedef struct packed {
      logic [7:0] data;
      logic       has;
      logic       last;
   } res_type;

   // One queue entry: the results caused by one accepted item
   typedef struct packed {
      res_type [1:0] res;
      logic          two;
   } entry_type;

   typedef struct packed {
      logic      push;
      entry_type entry;
   } qpush_type;

   // {is_digit, value}
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [7:0] t;
      t = 8'h00;
      if (b >= CH_0 && b <= CH_9) begin
         t = b - CH_0;
         return {1'b1, t[3:0]};
      end
      if (b >= CH_LA && b <= CH_LF) begin
         t = b - CH_LA + 8'd10;
         return {1'b1, t[3:0]};
      end
      if (b >= CH_UA && b <= CH_UF) begin
         t = b - CH_UA + 8'd10;
         return {1'b1, t[3:0]};
      end
      return 5'b0;
   endfunction

   function automatic logic is_oct(input logic [7:0] b);
      return (b >= CH_0 && b <= CH_7);
   endfunction

   // {is_simple_escape, control byte}
   function automatic logic [8:0] esc_char(input logic [7:0] b);
      logic [8:0] r;
      unique case (b)
         CH_N:    r = {1'b1, 8'h0A};
         CH_T:    r = {1'b1, 8'h09};
         CH_V:    r = {1'b1, 8'h0B};
         CH_B:    r = {1'b1, 8'h08};
         CH_R:    r = {1'b1, 8'h0D};
         CH_LF:   r = {1'b1, 8'h0C};
         CH_LA:   r = {1'b1, 8'h07};
         default: r = 9'h000;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/cse_front.sv]
// Front end: accepts escaped bytes, runs the escape parser and builds queue entries.
// Depends on cse_pkg.
`default_nettype none

module cse_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [7:0]         req_in_byte,
   input  wire logic               req_end_of_string,
   input  wire logic               q_full,
   output cse_pkg::qpush_type      q_out
);
   import cse_pkg::*;

   mode_type   mode_ff, mode_in;
   logic [7:0] value_ff, value_in;
   logic [2:0] count_ff, count_in;

   logic      accept;
   logic [1:0] k;
   res_type [1:0] res;
   logic [4:0] hd;
   logic [8:0] ec;
   logic [7:0] b;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign b         = req_in_byte;

   always_comb begin
      mode_in  = mode_ff;
      value_in = value_ff;
      count_in = count_ff;
      k        = 2'd0;
      res      = '0;
      hd       = hex_digit(b);
      ec       = esc_char(b);

      unique case (mode_ff)
         MODE_TEXT: begin
            if (b == CH_BSL) begin
               mode_in = MODE_ESC;
            end else begin
               res[k[0]] = '{data: b, has: 1'b1, last: 1'b0};
               k = k + 2'd1;
            end
         end
         MODE_ESC: begin
            mode_in = MODE_TEXT;
            if (ec[8]) begin
               res[k[0]] = '{data: ec[7:0], has: 1'b1, last: 1'b0};
               k = k + 2'd1;
            end else if (b == CH_X) begin
               mode_in  = MODE_HEX;
               value_in = 8'd0;
               count_in = 3'd0;
            end else if (is_oct(b)) begin
               mode_in  = MODE_OCT;
               value_in = {5'd0, b[2:0]};
               count_in = 3'd1;
               if (count_in >= 3'(OCT_DIGITS_MAX)) begin
                  res[k[0]] = '{data: value_in, has: 1'b1, last: 1'b0};
                  k = k + 2'd1;
                  mode_in  = MODE_TEXT;
                  value_in = 8'd0;
                  count_in = 3'd0;
               end
            end else begin
               res[k[0]] = '{data: b, has: 1'b1, last: 1'b0};
               k = k + 2'd1;
            end
         end
         MODE_HEX, MODE_OCT: begin
            if ((mode_ff == MODE_HEX) ? hd[4] : is_oct(b)) begin
               value_in = (mode_ff == MODE_HEX) ? {value_ff[3:0], hd[3:0]}
                                                : {value_ff[4:0], b[2:0]};
               count_in = count_ff + 3'd1;
               if (count_in >= ((mode_ff == MODE_HEX) ? 3'(HEX_DIGITS_MAX)
                                                      : 3'(OCT_DIGITS_MAX))) begin
                  res[k[0]] = '{data: value_in, has: 1'b1, last: 1'b0};
                  k = k + 2'd1;
                  mode_in  = MODE_TEXT;
                  value_in = 8'd0;
                  count_in = 3'd0;
               end
            end else begin
               // close the run, then treat the byte as plain text
               res[k[0]] = '{data: value_ff, has: 1'b1, last: 1'b0};
               k = k + 2'd1;
               mode_in  = MODE_TEXT;
               value_in = 8'd0;
               count_in = 3'd0;
               if (b == CH_BSL) begin
                  mode_in = MODE_ESC;
               end else begin
                  res[k[0]] = '{data: b, has: 1'b1, last: 1'b0};
                  k = k + 2'd1;
               end
            end
         end
         default: begin
            mode_in = MODE_TEXT;
         end
      endcase

      if (req_end_of_string) begin
         if (mode_in == MODE_HEX || mode_in == MODE_OCT) begin
            res[k[0]] = '{data: value_in, has: 1'b1, last: 1'b0};
            k = k + 2'd1;
         end
         mode_in  = MODE_TEXT;
         value_in = 8'd0;
         count_in = 3'd0;
         if (k == 2'd0) begin
            res[0] = '{data: 8'd0, has: 1'b0, last: 1'b0};
            k = 2'd1;
         end
         res[k[1]].last = 1'b1;
      end
   end

   assign q_out.push      = accept && (k != 2'd0);
   assign q_out.entry.res = res;
   assign q_out.entry.two = k[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_TEXT;
         value_ff <= 8'd0;
         count_ff <= 3'd0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         value_ff <= value_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

[rtl/cse_queue.sv]
// Short queue of result entries between the parser front end and the output back end.
// Depends on cse_pkg.
`default_nettype none

module cse_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cse_pkg::qpush_type  q_in,
   input  wire logic                pop,
   output logic                     full,
   output logic                     empty,
   output cse_pkg::entry_type       head
);
   import cse_pkg::*;

   entry_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wptr_ff, rptr_ff;
   logic [QPTR_W:0]       count_ff, count_in;

   assign full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rptr_ff];

   always_comb begin
      count_in = count_ff;
      if (q_in.push && !pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (!q_in.push && pop) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (q_in.push) begin
         slot_ff[wptr_ff] <= q_in.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (q_in.push) begin
            wptr_ff <= wptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rptr_ff <= rptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_in.push |-> (!full || pop)) else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("pop from empty queue");
   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      (q_in.push && !pop) |=> (count_ff == $past(count_ff) + (QPTR_W+1)'(1)))
      else $error("queue count did not advance on push");
`endif

endmodule

`default_nettype wire

[rtl/cse_back.sv]
// Back end: drains the queue, one decoded result per cycle unless stalled.
// Depends on cse_pkg.
`default_nettype none

module cse_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cse_pkg::entry_type  head,
   input  wire logic                empty,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_has_byte,
   output logic                     rsp_last_of_string
);
   import cse_pkg::*;

   logic    valid_ff;
   logic    sub_ff;
   res_type out_ff;
   logic    load, take;

   // output register refills when empty or when its item is being taken
   assign load = !valid_ff || rsp_ready;
   assign take = load && !empty;
   assign pop  = take && (sub_ff || !head.two);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 1'b0;
      end else if (take) begin
         valid_ff <= 1'b1;
         sub_ff   <= !pop;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_ff <= head.res[sub_ff];
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_out_byte       = out_ff.data;
   assign rsp_has_byte       = out_ff.has;
   assign rsp_last_of_string = out_ff.last;

endmodule

`default_nettype wire

[rtl/c_string_unescaper.sv]
// Top level of the C string unescaper: front end, entry queue and output back end.
// Depends on cse_pkg, cse_front, cse_queue and cse_back.
//
// Accepts one escaped byte per cycle whenever the four-entry result queue has room,
// and delivers one decoded result per cycle through a registered output while the
// receiver is ready. An item that yields two results (a digit run closed by a plain
// byte) passes them to the output one after the other, so with no stall the
// sustained rate is one item per cycle for single-result items and set by the single
// output port otherwise. Results pass a queue slot, then the output register.
`default_nettype none

module c_string_unescaper (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_end_of_string,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_has_byte,
   output logic             rsp_last_of_string
);
   import cse_pkg::*;

   qpush_type qp;
   entry_type head;
   logic      full, empty, pop;

   cse_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_end_of_string (req_end_of_string),
      .q_full            (full),
      .q_out             (qp)
   );

   cse_queue u_queue (
      .clock (clock),
      .reset (reset),
      .q_in  (qp),
      .pop   (pop),
      .full  (full),
      .empty (empty),
      .head  (head)
   );

   cse_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .empty              (empty),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_has_byte       (rsp_has_byte),
      .rsp_last_of_string (rsp_last_of_string)
   );

endmodule

`default_nettype wire

[test/tb_c_string_unescaper.sv]
// Self-checking testbench for c_string_unescaper: directed escape cases, then random
// escaped strings under several idle/stall profiles. Depends on cse_pkg and the RTL.
`timescale 1ns / 100ps

module tb_c_string_unescaper;
   import cse_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int TAIL_CYCLES = 8;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_end_of_string = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_has_byte;
   logic       rsp_last_of_string;

   // Decoder state mirrored by the testbench
   mode_type   dec_mode;
   logic [7:0] dec_value;
   logic [2:0] dec_count;
   res_type    step_res[$];
   res_type    decoded_q[$];

   int tx_idle_pct = 0;
   int rx_stall_pct = 0;
   int items_sent = 0;
   int results_seen = 0;
   int strings_ended = 0;
   int mismatches = 0;
   int quiet_cycles = 0;

   c_string_unescaper DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_byte        (req_in_byte),
      .req_end_of_string  (req_end_of_string),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_has_byte       (rsp_has_byte),
      .rsp_last_of_string (rsp_last_of_string)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void emit_byte(input logic [7:0] d);
      step_res.push_back(res_type'({d, 1'b1, 1'b0}));
   endfunction

   function automatic void back_to_text();
      dec_mode  = MODE_TEXT;
      dec_value = 8'h00;
      dec_count = 3'd0;
   endfunction

   function automatic void text_in(input logic [7:0] b);
      if (b == CH_BSL) begin
         dec_mode = MODE_ESC;
      end else begin
         emit_byte(b);
      end
   endfunction

   // Hex digit value, or -1 for a byte that is not a hex digit
   function automatic int hex_value_of(input logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b) - int'("0");
      if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
      if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
      return -1;
   endfunction

   // Advance the mirrored decoder by one byte and queue the decoded results
   function automatic void decode_item(input logic [7:0] b, input logic eos);
      int      d;
      res_type tail;
      step_res.delete();
      case (dec_mode)
         MODE_TEXT: text_in(b);
         MODE_ESC: begin
            dec_mode = MODE_TEXT;
            case (b)
               CH_N:  emit_byte(8'h0A);
               CH_T:  emit_byte(8'h09);
               CH_V:  emit_byte(8'h0B);
               CH_B:  emit_byte(8'h08);
               CH_R:  emit_byte(8'h0D);
               CH_LF: emit_byte(8'h0C);
               CH_LA: emit_byte(8'h07);
               CH_X: begin
                  dec_mode  = MODE_HEX;
                  dec_value = 8'h00;
                  dec_count = 3'd0;
               end
               default: begin
                  if (b >= CH_0 && b <= CH_7) begin
                     dec_mode  = MODE_OCT;
                     dec_value = b - CH_0;
                     dec_count = 3'd1;
                     if (dec_count >= OCT_DIGITS_MAX) begin
                        emit_byte(dec_value);
                        back_to_text();
                     end
                  end else begin
                     emit_byte(b);
                  end
               end
            endcase
         end
         MODE_HEX: begin
            d = hex_value_of(b);
            if (d >= 0) begin
               dec_value = {dec_value[3:0], 4'h0} + 8'(d);
               dec_count = dec_count + 3'd1;
               if (dec_count >= HEX_DIGITS_MAX) begin
                  emit_byte(dec_value);
                  back_to_text();
               end
            end else begin
               // close the run, then treat the byte as ordinary text
               emit_byte(dec_value);
               back_to_text();
               text_in(b);
            end
         end
         default: begin
            if (b >= CH_0 && b <= CH_7) begin
               dec_value = {dec_value[4:0], 3'b000} + (b - CH_0);
               dec_count = dec_count + 3'd1;
               if (dec_count >= OCT_DIGITS_MAX) begin
                  emit_byte(dec_value);
                  back_to_text();
               end
            end else begin
               emit_byte(dec_value);
               back_to_text();
               text_in(b);
            end
         end
      endcase
      if (eos) begin
         if (dec_mode == MODE_HEX || dec_mode == MODE_OCT) emit_byte(dec_value);
         back_to_text();
         if (step_res.size() == 0) step_res.push_back(res_type'({8'h00, 1'b0, 1'b0}));
         tail = step_res.pop_back();
         tail.last = 1'b1;
         step_res.push_back(tail);
         strings_ended++;
      end
      foreach (step_res[i]) decoded_q.push_back(step_res[i]);
   endfunction

   // Offer one item; valid stays high across back-to-back items
   task automatic send_item(input logic [7:0] b, input logic eos);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_valid         <= 1'b1;
      req_in_byte       <= b;
      req_end_of_string <= eos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      decode_item(b, eos);
      items_sent++;
   endtask

   // Hold off the sender until every decoded byte has come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (decoded_q.size() != 0);
   endtask

   function automatic logic pick_eos();
      return ($urandom_range(9) == 0);
   endfunction

   function automatic logic [7:0] rand_hex_char();
      string digits;
      digits = "0123456789abcdefABCDEF";
      return digits[$urandom_range(21)];
   endfunction

   task automatic send_escape_token();
      int n;
      case ($urandom_range(9))
         0, 1: send_item(8'($urandom_range(255)), pick_eos());
         2, 3: begin
            send_item(CH_BSL, pick_eos());
            case ($urandom_range(6))
               0: send_item(CH_N, pick_eos());
               1: send_item(CH_T, pick_eos());
               2: send_item(CH_V, pick_eos());
               3: send_item(CH_B, pick_eos());
               4: send_item(CH_R, pick_eos());
               5: send_item(CH_LF, pick_eos());
               default: send_item(CH_LA, pick_eos());
            endcase
         end
         4, 5: begin
            send_item(CH_BSL, pick_eos());
            send_item(CH_X, pick_eos());
            n = $urandom_range(5);
            repeat (n) send_item(rand_hex_char(), pick_eos());
         end
         6, 7: begin
            send_item(CH_BSL, pick_eos());
            n = $urandom_range(1, 4);
            repeat (n) send_item(CH_0 + 8'($urandom_range(7)), pick_eos());
         end
         8: begin
            send_item(CH_BSL, pick_eos());
            send_item(8'($urandom_range(255)), pick_eos());
         end
         default: begin
            n = $urandom_range(1, 3);
            repeat (n) send_item(8'($urandom_range(255)), pick_eos());
         end
      endcase
   endtask

   task automatic test_directed_cases();
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(CH_BSL, 1'b0);
      send_item("n", 1'b0);
      // hex run stops at its digit limit, mixed-case letters
      send_item(CH_BSL, 1'b0);
      send_item("x", 1'b0);
      send_item("F", 1'b0);
      send_item("f", 1'b0);
      send_item("0", 1'b0);
      send_item("9", 1'b0);
      // empty hex run closed by a backslash that opens an octal run
      send_item(CH_BSL, 1'b0);
      send_item("x", 1'b0);
      send_item(CH_BSL, 1'b0);
      send_item("7", 1'b0);
      send_item("7", 1'b0);
      send_item("7", 1'b0);
      // octal run closed by a non-octal digit
      send_item(CH_BSL, 1'b0);
      send_item("1", 1'b0);
      send_item("8", 1'b0);
      send_item(CH_BSL, 1'b0);
      send_item("\"", 1'b0);
      // runs flushed at end of string
      send_item(CH_BSL, 1'b0);
      send_item("x", 1'b0);
      send_item("a", 1'b1);
      send_item(CH_BSL, 1'b0);
      send_item("4", 1'b1);
      send_item(CH_BSL, 1'b0);
      send_item("x", 1'b1);
      // lone trailing backslash leaves only the end marker
      send_item(CH_BSL, 1'b1);
      send_item("A", 1'b1);
   endtask

   task automatic test_escape_stream(input int tx_pct, input int rx_pct, input int count);
      int stop_at;
      int half_at;
      tx_idle_pct  = tx_pct;
      rx_stall_pct = rx_pct;
      stop_at = items_sent + count;
      half_at = items_sent + count / 2;
      while (items_sent < half_at) send_escape_token();
      wait_drained();
      while (items_sent < stop_at) send_escape_token();
   endtask

   always @(posedge clock) begin
      res_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (decoded_q.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual byte %02h has %b last %b",
                     $time, rsp_out_byte, rsp_has_byte, rsp_last_of_string);
            mismatches++;
         end else begin
            want = decoded_q.pop_front();
            if (want.data !== rsp_out_byte || want.has !== rsp_has_byte ||
                want.last !== rsp_last_of_string) begin
               $display("%0t: mismatch: expected byte %02h has %b last %b, actual byte %02h has %b last %b",
                        $time, want.data, want.has, want.last,
                        rsp_out_byte, rsp_has_byte, rsp_last_of_string);
               mismatches++;
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                  $time, QUIET_LIMIT, decoded_q.size());
         $display("tb_c_string_unescaper NOT OK");
         $finish;
      end
   end

   initial begin
      back_to_text();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_escape_stream(0, 0, 110);
      test_escape_stream(73, 0, 110);
      test_escape_stream(0, 73, 110);
      test_escape_stream(11, 11, 110);
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d bytes in %0d terminated strings, checked %0d decoded results",
               items_sent, strings_ended, results_seen);
      $display("across four sender/receiver idle profiles; %0d mismatches", mismatches);
      if (mismatches == 0) begin
         $display("tb_c_string_unescaper OK");
      end else begin
         $display("tb_c_string_unescaper NOT OK");
      end
      $finish;
   end

endmodule

[files.f]
rtl/cse_pkg.sv
rtl/cse_front.sv
rtl/cse_queue.sv
rtl/cse_back.sv
rtl/c_string_unescaper.sv
test/tb_c_string_unescaper.sv
